// ----- hw/rtl/quad_x_mixer_with_lag_core_macros.svh -----
// Assertion macros used by the mixer top level.
`ifndef QUAD_X_MIXER_WITH_LAG_CORE_MACROS_SVH
`define QUAD_X_MIXER_WITH_LAG_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define QXM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("quad mixer check failed");
// Next-cycle implication, checked outside reset.
`define QXM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("quad mixer check failed");
`else
`define QXM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define QXM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/qxm_pkg.sv -----
// Shared types and constants of the quad X mixer.
package qxm_pkg;

    localparam int CMD_W      = 16;
    localparam int ALPHA_W    = 16;
    localparam int LEVEL_OUT_W = 15;
    localparam int MOTOR_COUNT = 4;

    localparam int MOTOR_REAR_LEFT   = 0;
    localparam int MOTOR_FRONT_LEFT  = 1;
    localparam int MOTOR_FRONT_RIGHT = 2;
    localparam int MOTOR_REAR_RIGHT  = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd13107;

    typedef struct packed {
        logic signed [CMD_W-1:0] thrust;
        logic signed [CMD_W-1:0] roll;
        logic signed [CMD_W-1:0] pitch;
        logic signed [CMD_W-1:0] yaw;
    } t_cmd;

endpackage

// ----- hw/rtl/qxm_mix.sv -----
// Motor mixing, desaturation and clamping into the target register.
module qxm_mix
    import qxm_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    parameter int LW        = FRAC_BITS + 1
) (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  t_cmd                             i_cmd,
    output logic [MOTOR_COUNT-1:0][LW-1:0]   o_tgt,
    output logic                             o_reduced
);

    // Wide enough for the four-term sums and for 1.0 at any fraction width.
    localparam int MW = (FRAC_BITS + 3 > 20) ? FRAC_BITS + 3 : 20;
    localparam logic signed [MW-1:0] ONE = MW'(1) << FRAC_BITS;

    logic signed [MW-1:0] tt, rr, pp, yn;
    logic signed [MW-1:0] mix [MOTOR_COUNT];
    logic signed [MW-1:0] max_a, max_b, mx, excess;
    logic signed [MW-1:0] adj [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0][LW-1:0] n_tgt;
    logic                 n_reduced;
    logic [MOTOR_COUNT-1:0][LW-1:0] r_tgt;
    logic                 r_reduced;

    always_comb begin
        tt = MW'(i_cmd.thrust);
        rr = MW'(i_cmd.roll);
        pp = MW'(i_cmd.pitch);
        yn = -MW'(i_cmd.yaw);

        mix[MOTOR_REAR_LEFT]   = tt - rr + pp + yn;
        mix[MOTOR_FRONT_LEFT]  = tt - rr - pp - yn;
        mix[MOTOR_FRONT_RIGHT] = tt + rr - pp + yn;
        mix[MOTOR_REAR_RIGHT]  = tt + rr + pp - yn;

        max_a = (mix[MOTOR_FRONT_LEFT] > mix[MOTOR_REAR_LEFT]) ?
                mix[MOTOR_FRONT_LEFT] : mix[MOTOR_REAR_LEFT];
        max_b = (mix[MOTOR_REAR_RIGHT] > mix[MOTOR_FRONT_RIGHT]) ?
                mix[MOTOR_REAR_RIGHT] : mix[MOTOR_FRONT_RIGHT];
        mx    = (max_b > max_a) ? max_b : max_a;

        n_reduced = (mx > ONE);
        excess    = n_reduced ? (mx - ONE) : '0;

        for (int i = 0; i < MOTOR_COUNT; i++) begin
            adj[i] = mix[i] - excess;
            if (adj[i] < 0) begin
                n_tgt[i] = '0;
            end else if (adj[i] > ONE) begin
                n_tgt[i] = ONE[LW-1:0];
            end else begin
                n_tgt[i] = adj[i][LW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tgt     <= n_tgt;
            r_reduced <= n_reduced;
        end
    end

    assign o_tgt     = r_tgt;
    assign o_reduced = r_reduced;

endmodule

// ----- hw/rtl/qxm_lag.sv -----
// First-order lag on the four motor levels; the level registers are also the result.
module qxm_lag
    import qxm_pkg::*;
#(
    parameter int LW = 15
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  logic [ALPHA_W-1:0]               i_alpha,
    input  logic [MOTOR_COUNT-1:0][LW-1:0]   i_tgt,
    input  logic                             i_reduced,
    output logic [MOTOR_COUNT-1:0][LW-1:0]   o_level,
    output logic                             o_reduced
);

    localparam int DW = LW + 1;
    localparam int PW = DW + ALPHA_W + 1;

    logic signed [DW-1:0] diff  [MOTOR_COUNT];
    logic signed [PW-1:0] prod  [MOTOR_COUNT];
    logic signed [PW-1:0] delta [MOTOR_COUNT];
    logic signed [DW-1:0] sum   [MOTOR_COUNT];
    logic signed [ALPHA_W:0] alpha_s;
    logic [MOTOR_COUNT-1:0][LW-1:0] n_level;
    logic [MOTOR_COUNT-1:0][LW-1:0] r_level;
    logic                 r_reduced;

    always_comb begin
        alpha_s = {1'b0, i_alpha};
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            diff[i]  = $signed({1'b0, i_tgt[i]}) - $signed({1'b0, r_level[i]});
            prod[i]  = PW'(alpha_s) * PW'(diff[i]);
            // Arithmetic shift gives the floor for negative products.
            delta[i] = prod[i] >>> ALPHA_W;
            sum[i]   = $signed({1'b0, r_level[i]}) + delta[i][DW-1:0];
            n_level[i] = sum[i][LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_load) begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_reduced <= i_reduced;
        end
    end

    assign o_level   = r_level;
    assign o_reduced = r_reduced;

endmodule

// ----- hw/rtl/quad_x_mixer_with_lag_core.sv -----
// Top level of the quad X motor mixer with desaturation and motor lag.
// One command is accepted per clock while the output is not stalled; its result
// is offered after it has passed three registers: an input register, a register
// of clamped targets after mixing and desaturation, and the motor level
// registers after the lag multiply. The level registers close a loop through
// the four lag multipliers with no other register in it, which is what sets
// the rate of one command per cycle. Ready on the input side follows output
// ready combinationally when all three stages are full. The user must write the
// lag coefficient over the configuration channel only while no command is in
// flight; the block does not enforce this. It resets to 13107 (about 0.2).
`include "quad_x_mixer_with_lag_core_macros.svh"

module quad_x_mixer_with_lag_core
    import qxm_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [ALPHA_W-1:0]      i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [CMD_W-1:0] i_thrust_cmd,
    input  logic signed [CMD_W-1:0] i_roll_cmd,
    input  logic signed [CMD_W-1:0] i_pitch_cmd,
    input  logic signed [CMD_W-1:0] i_yaw_cmd,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [LEVEL_OUT_W-1:0]  o_rear_left_level,
    output logic [LEVEL_OUT_W-1:0]  o_front_left_level,
    output logic [LEVEL_OUT_W-1:0]  o_front_right_level,
    output logic [LEVEL_OUT_W-1:0]  o_rear_right_level,
    output logic                    o_thrust_reduced
);

    localparam int LW = FRAC_BITS + 1;
    localparam int OW = (LW > LEVEL_OUT_W) ? LW : LEVEL_OUT_W;

    logic [ALPHA_W-1:0] r_alpha;
    t_cmd               r_cmd;
    logic               r_in_vld, r_tgt_vld, r_out_vld;
    logic               n_in_vld, n_tgt_vld, n_out_vld;
    logic               out_free, tgt_free, in_free;
    logic               in_take, in_move, tgt_move;
    logic [MOTOR_COUNT-1:0][LW-1:0] tgt;
    logic [MOTOR_COUNT-1:0][LW-1:0] level;
    logic               tgt_reduced;
    logic [OW-1:0]      level_ext [MOTOR_COUNT];

    // Stage handshakes: a stage may load when it is empty or being emptied.
    always_comb begin
        out_free = !r_out_vld || i_ready;
        tgt_move = r_tgt_vld && out_free;
        tgt_free = !r_tgt_vld || out_free;
        in_move  = r_in_vld && tgt_free;
        in_free  = !r_in_vld || tgt_free;
        in_take  = i_valid && in_free;

        n_in_vld  = in_free  ? i_valid   : 1'b1;
        n_tgt_vld = tgt_free ? r_in_vld  : 1'b1;
        n_out_vld = out_free ? r_tgt_vld : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_tgt_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_alpha   <= ALPHA_RESET;
        end else begin
            r_in_vld  <= n_in_vld;
            r_tgt_vld <= n_tgt_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                r_alpha <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd.thrust <= i_thrust_cmd;
            r_cmd.roll   <= i_roll_cmd;
            r_cmd.pitch  <= i_pitch_cmd;
            r_cmd.yaw    <= i_yaw_cmd;
        end
    end

    qxm_mix #(
        .FRAC_BITS (FRAC_BITS),
        .LW        (LW)
    ) u_mix (
        .i_clk     (i_clk),
        .i_load    (in_move),
        .i_cmd     (r_cmd),
        .o_tgt     (tgt),
        .o_reduced (tgt_reduced)
    );

    qxm_lag #(
        .LW        (LW)
    ) u_lag (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (tgt_move),
        .i_alpha   (r_alpha),
        .i_tgt     (tgt),
        .i_reduced (tgt_reduced),
        .o_level   (level),
        .o_reduced (o_thrust_reduced)
    );

    always_comb begin
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            level_ext[i] = OW'(level[i]);
        end
    end

    assign o_cfg_ready         = 1'b1;
    assign o_ready             = in_free;
    assign o_valid             = r_out_vld;
    assign o_rear_left_level   = level_ext[MOTOR_REAR_LEFT][LEVEL_OUT_W-1:0];
    assign o_front_left_level  = level_ext[MOTOR_FRONT_LEFT][LEVEL_OUT_W-1:0];
    assign o_front_right_level = level_ext[MOTOR_FRONT_RIGHT][LEVEL_OUT_W-1:0];
    assign o_rear_right_level  = level_ext[MOTOR_REAR_RIGHT][LEVEL_OUT_W-1:0];

    // A finished target must wait while the result is stalled.
    `QXM_ASSERT_NEXT(a_tgt_held, i_clk, i_rst_n, r_tgt_vld && r_out_vld && !i_ready, r_tgt_vld)
    // With nothing behind it, a taken result leaves the output empty.
    `QXM_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n, r_out_vld && i_ready && !r_tgt_vld, !o_valid)
    // A zero coefficient freezes the motor levels.
    `QXM_ASSERT_NEXT(a_alpha_zero_holds, i_clk, i_rst_n, tgt_move && (r_alpha == '0), $stable(level))

endmodule
